[design/stop_sequence_detector_macros.svh]
// assertion helpers for the stop sequence detector
`ifndef STOP_SEQUENCE_DETECTOR_MACROS_SVH
`define STOP_SEQUENCE_DETECTOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define SSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/ssd_pkg.sv]
package ssd_pkg;
  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOSEQ  = 2'd1,
    ST_BADLN  = 2'd2,
    ST_RSVD   = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic [2:0] REG_LANE_COUNT = 3'd0;
  localparam logic [2:0] REG_SEQ0_LEN   = 3'd1;
  localparam int unsigned LEN_REGS      = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_CLEAR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  lane;
    logic [19:0] token;
    logic [1:0]  slot;
    logic [2:0]  position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        stopped;
    logic [3:0]  partial_progress;
    logic [15:0] matched_length;
    logic        all_done;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [3:0]  data;
  } cfg_t;
endpackage

[design/ssd_if.sv]
interface ssd_req_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssd_rsp_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssd_cfg_if;
  import ssd_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/stop_sequence_detector.sv]
// stop sequence detector
// req channel: kind 0 feeds one token to a lane, kind 1 writes one stop
// sequence token at slot/position, kind 2 clears every lane, kind 3 is ignored.
// cfg channel: index 0 lane count, indexes 1..4 slot lengths (4 bit data);
// the user writes it only while no request is in flight; the block won't check.
// rsp channel: exactly one response per request, in order.
// the lane state memory is read on the accepting edge; the request then passes
// through S_READ (append), S_CHECK (compare and write back) and S_WRITE (all
// done flag) before the response is registered, and a new request is taken
// only once the block is back in idle, clears included.
// a stalled receiver holds one response in the output register; the next
// request runs up to its last stage and waits there, and req ready stays low
// until the output register frees up.
// reset clears every lane through the flip-flop valid bits, the slot lengths
// to 0 and the lane count to 1; a clear request drops the valid and stop bits.
// pattern tokens are undefined until written.
module stop_sequence_detector #(
  parameter int unsigned LANES      = 8,
  parameter int unsigned MAX_LEN    = 8,
  parameter int unsigned NUM_SEQ    = 4,
  parameter int unsigned TOKEN_BITS = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssd_req_if.sink   req,
  ssd_cfg_if.sink   cfg,
  ssd_rsp_if.source rsp
);
  import ssd_pkg::*;

  localparam int unsigned LaneW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned PosW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SlotW = (NUM_SEQ > 1) ? $clog2(NUM_SEQ) : 1;
  localparam int unsigned RowW  = MAX_LEN * TOKEN_BITS + LenW + 1 + LenW + 16;

  typedef struct packed {
    logic [MAX_LEN-1:0][TOKEN_BITS-1:0] hist;
    logic [LenW-1:0]                    fill;
    logic                               stopped;
    logic [LenW-1:0]                    prog;
    logic [15:0]                        mlen;
  } row_t;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   res_q, res_d;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic [3:0] lane_count_q;
  logic [LEN_REGS-1:0][3:0] len_reg_q;
  logic [LANES-1:0] row_valid_q, row_valid_d;
  logic [LANES-1:0] stop_q, stop_d;
  row_t row_rd, row_fix, row_new, row_q, row_d;
  logic [RowW-1:0] row_rdata;
  logic row_we;
  logic [LaneW-1:0] lane_idx;
  logic [LaneW-1:0] rd_idx;

  // pattern storage, registers per slot
  logic [NUM_SEQ-1:0][MAX_LEN-1:0][TOKEN_BITS-1:0] pat_q;
  logic [NUM_SEQ-1:0][LenW-1:0] slot_len;
  logic any_seq;
  logic [LaneW:0] active;
  logic lane_ok;
  logic m_full;
  logic [LenW-1:0] m_prog;

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q <= 4'd1;
      len_reg_q    <= '0;
    end else if (cfg.valid) begin
      if (cfg.data.index == REG_LANE_COUNT) begin
        lane_count_q <= cfg.data.data;
      end else begin
        for (int r = 0; r < LEN_REGS; r++) begin
          if (cfg.data.index == REG_SEQ0_LEN + 3'(r)) len_reg_q[r] <= cfg.data.data;
        end
      end
    end
  end

  // effective slot lengths and lane count
  always_comb begin
    any_seq = 1'b0;
    for (int s = 0; s < NUM_SEQ; s++) begin
      slot_len[s] = '0;
      if (s < LEN_REGS) begin
        slot_len[s] = (32'(len_reg_q[s]) > MAX_LEN) ? LenW'(MAX_LEN)
                                                  : LenW'(len_reg_q[s]);
      end
      if (slot_len[s] != '0) any_seq = 1'b1;
    end
    if (lane_count_q == 4'd0) active = (LaneW+1)'(1);
    else if (32'(lane_count_q) > LANES) active = (LaneW+1)'(LANES);
    else active = (LaneW+1)'(lane_count_q);
    lane_ok = (32'(req_q.lane) < 32'(active));
  end

  // pattern token writes
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ && req_q.kind == KIND_WRITE &&
        32'(req_q.slot) < NUM_SEQ && 32'(req_q.position) < MAX_LEN) begin
      pat_q[req_q.slot[SlotW-1:0]][req_q.position[PosW-1:0]] <=
        req_q.token[TOKEN_BITS-1:0];
    end
  end

  assign lane_idx = req_q.lane[LaneW-1:0];
  // read the requested lane on the accepting edge
  assign rd_idx   = (state_q == S_IDLE) ? req.data.lane[LaneW-1:0] : lane_idx;

  // lane state memory
  ssd_ram #(.Width(RowW), .Depth(LANES)) u_lane_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (lane_idx),
    .wdata_i (row_new),
    .raddr_i (rd_idx),
    .rdata_o (row_rdata)
  );

  assign row_rd  = row_t'(row_rdata);
  assign row_fix = row_valid_q[lane_idx] ? row_rd : row_t'('0);

  // append the new token to the fetched row
  always_comb begin
    row_d = row_fix;
    if (!row_fix.stopped) begin
      if (32'(row_fix.fill) < MAX_LEN) begin
        row_d.hist[row_fix.fill[PosW-1:0]] = req_q.token[TOKEN_BITS-1:0];
        row_d.fill = row_fix.fill + LenW'(1);
      end else begin
        for (int i = 0; i < MAX_LEN - 1; i++) row_d.hist[i] = row_fix.hist[i+1];
        row_d.hist[MAX_LEN-1] = req_q.token[TOKEN_BITS-1:0];
      end
    end
  end

  ssd_match #(.MaxLen(MAX_LEN), .NumSeq(NUM_SEQ), .TokBits(TOKEN_BITS)) u_match (
    .hist_i (row_q.hist),
    .fill_i (row_q.fill),
    .pat_i  (pat_q),
    .len_i  (slot_len),
    .full_o (m_full),
    .prog_o (m_prog)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      row_valid_q <= '0;
      stop_q      <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      row_valid_q <= row_valid_d;
      stop_q      <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
    res_q <= res_d;
    rsp_q <= rsp_d;
    if (state_q == S_READ) row_q <= row_d;
  end

  always_comb begin
    logic done_all;
    done_all    = 1'b1;
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    row_valid_d = row_valid_q;
    stop_d      = stop_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    row_we      = 1'b0;
    row_new     = row_q;
    req.ready   = (state_q == S_IDLE);
    // output register drains on its own handshake
    if (rsp_valid_q && rsp.ready) rsp_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
        res_d   = '0;
        if (req_q.kind == KIND_TOKEN) begin
          if (!lane_ok) res_d.status = ST_BADLN;
          else if (!any_seq) res_d.status = ST_NOSEQ;
        end
        if (req_q.kind == KIND_CLEAR) begin
          row_valid_d = '0;
          stop_d      = '0;
        end
      end
      S_CHECK: begin
        state_d = S_WRITE;
        if (req_q.kind == KIND_TOKEN && res_q.status == ST_OK) begin
          if (row_q.stopped) begin
            if (row_q.mlen != 16'hFFFF) row_new.mlen = row_q.mlen + 16'd1;
          end else begin
            row_new.prog = m_prog;
            if (m_full) begin
              row_new.stopped = 1'b1;
              row_new.mlen    = 16'(m_prog);
            end
          end
          row_we               = 1'b1;
          row_valid_d[lane_idx] = 1'b1;
          stop_d[lane_idx]      = row_new.stopped;
          res_d.stopped          = row_new.stopped;
          res_d.partial_progress = 4'(row_new.prog);
          res_d.matched_length   = row_new.mlen;
        end
      end
      S_WRITE: begin
        for (int i = 0; i < LANES; i++) begin
          if (32'(i) < 32'(active) && !stop_q[i]) done_all = 1'b0;
        end
        // hand over once the output register is free
        if (!rsp_valid_q || rsp.ready) begin
          rsp_d          = res_q;
          rsp_d.all_done = done_all;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;
endmodule

[design/ssd_ram.sv]
module ssd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/ssd_match.sv]
// compares one lane history row against all pattern slots
module ssd_match #(
  parameter int unsigned MaxLen  = 8,
  parameter int unsigned NumSeq  = 4,
  parameter int unsigned TokBits = 20,
  parameter int unsigned LenW    = $clog2(MaxLen + 1)
) (
  input  logic [MaxLen-1:0][TokBits-1:0]        hist_i,
  input  logic [LenW-1:0]                       fill_i,
  input  logic [NumSeq-1:0][MaxLen-1:0][TokBits-1:0] pat_i,
  input  logic [NumSeq-1:0][LenW-1:0]           len_i,
  output logic                                  full_o,
  output logic [LenW-1:0]                       prog_o
);
  localparam int unsigned PosW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  // eq[s][k]: newest k history tokens equal the first k tokens of slot s
  logic [NumSeq-1:0][MaxLen:0] eq;

  always_comb begin
    for (int s = 0; s < NumSeq; s++) begin
      for (int k = 0; k <= MaxLen; k++) begin
        eq[s][k] = (LenW'(k) <= fill_i);
        for (int i = 0; i < MaxLen; i++) begin
          if (i < k && LenW'(k) <= fill_i) begin
            if (hist_i[PosW'(32'(fill_i) + 32'(i) - 32'(k))] != pat_i[s][i]) begin
              eq[s][k] = 1'b0;
            end
          end
        end
      end
    end
  end

  // slot order scan: first full match wins, else longest proper prefix
  always_comb begin
    logic done;
    done   = 1'b0;
    full_o = 1'b0;
    prog_o = '0;
    for (int s = 0; s < NumSeq; s++) begin
      if (!done && len_i[s] != '0) begin
        if (eq[s][len_i[s]]) begin
          full_o = 1'b1;
          prog_o = len_i[s];
          done   = 1'b1;
        end else begin
          for (int k = 1; k < MaxLen; k++) begin
            if (LenW'(k) < len_i[s] && eq[s][k] && LenW'(k) > prog_o) begin
              prog_o = LenW'(k);
            end
          end
        end
      end
    end
  end
endmodule

[design/ssd_checker.sv]
module ssd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_status_i
);
  import ssd_pkg::*;
  `include "stop_sequence_detector_macros.svh"
  `SSD_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_status_i))
  `SSD_ASSERT_NEXT(a_rsp_held, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `SSD_ASSERT_NEXT(a_req_blocks, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  `SSD_ASSERT_IMPL(a_status_code, clk_i, rst_ni, rsp_valid_i, rsp_status_i != ST_RSVD)
endmodule

bind stop_sequence_detector ssd_checker u_ssd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_status_i (rsp.data.status)
);
